@@ rtl/cag_pkg.sv @@
// ----------------------------------------------------------------------------
// Collision alarm grader package
// Shared types, register indexes, level codes and reset values.
// ----------------------------------------------------------------------------
package cag_pkg;

    localparam int unsigned DIST_W  = 13;
    localparam int unsigned SPEED_W = 12;
    localparam int unsigned LIMIT_W = 7;
    localparam int unsigned CFG_W   = 13;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned SCALE_W = 17;
    localparam int unsigned PROD_W  = 24;
    localparam int unsigned CNT_W   = 4;

    localparam logic [CNT_W-1:0] HOLD_SAMPLES = 4'd3;

    localparam logic [IDX_W-1:0] REG_FRONT_WARN_DIST = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRONT_CRIT_DIST = 3'd1;
    localparam logic [IDX_W-1:0] REG_TTC_WARN_LIMIT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_TTC_CRIT_LIMIT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SIDE_RANGE      = 3'd4;
    localparam logic [IDX_W-1:0] REG_SIDE_MIN_SPEED  = 3'd5;
    localparam logic [IDX_W-1:0] REG_OVERSPEED_LIMIT = 3'd6;
    localparam logic [IDX_W-1:0] REG_SENSOR_MAX_DIST = 3'd7;

    localparam logic [1:0] LEVEL_NONE = 2'd0;
    localparam logic [1:0] LEVEL_WARN = 2'd1;
    localparam logic [1:0] LEVEL_CRIT = 2'd2;

    localparam logic [1:0] ALARM_QUIET  = 2'd0;
    localparam logic [1:0] ALARM_NOTICE = 2'd1;
    localparam logic [1:0] ALARM_WARN   = 2'd2;
    localparam logic [1:0] ALARM_CRIT   = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0]  front_warn_dist;
        logic [DIST_W-1:0]  front_crit_dist;
        logic [LIMIT_W-1:0] ttc_warn_limit;
        logic [LIMIT_W-1:0] ttc_crit_limit;
        logic [DIST_W-1:0]  side_range;
        logic [SPEED_W-1:0] side_min_speed;
        logic [SPEED_W-1:0] overspeed_limit;
        logic [DIST_W-1:0]  sensor_max_dist;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        front_warn_dist: 13'd500,
        front_crit_dist: 13'd200,
        ttc_warn_limit:  7'd30,
        ttc_crit_limit:  7'd15,
        side_range:      13'd300,
        side_min_speed:  12'd200,
        overspeed_limit: 12'd1200,
        sensor_max_dist: 13'd4000
    };

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [DIST_W-1:0]  front_dist;
        logic [DIST_W-1:0]  left_dist;
        logic [DIST_W-1:0]  right_dist;
        logic [SCALE_W-1:0] speed_x25;
        logic [SCALE_W-1:0] front_x9;
    } item_t;

endpackage

@@ rtl/collision_alarm_grader_unit.sv @@
// ----------------------------------------------------------------------------
// Collision alarm grader
// Path: a beat taken at the input is registered in the input stage, then graded
// and registered in the result register before it is shown at the output.
// Throughput: one beat per cycle; the input stage and the result register
// each hold one beat, so a stalled output backs up through both.
// Reset (asynchronous, active low) loads the default thresholds, clears the
// held level and settle counter, and empties both stages.
// ----------------------------------------------------------------------------
module collision_alarm_grader_unit
    import cag_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SPEED_W-1:0] speed,
    input  logic [DIST_W-1:0]  front_dist,
    input  logic [DIST_W-1:0]  left_dist,
    input  logic [DIST_W-1:0]  right_dist,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         collision_level,
    output logic               blind_left,
    output logic               blind_right,
    output logic [1:0]         alarm_level,
    output logic               ttc_active
);

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_take;

    cag_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cag_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .speed      (speed),
        .front_dist (front_dist),
        .left_dist  (left_dist),
        .right_dist (right_dist),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    cag_grade u_grade (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .item_valid      (item_valid),
        .item_take       (item_take),
        .item            (item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .collision_level (collision_level),
        .blind_left      (blind_left),
        .blind_right     (blind_right),
        .alarm_level     (alarm_level),
        .ttc_active      (ttc_active)
    );

`ifndef SYNTHESIS
    // The collision level never takes the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (collision_level <= LEVEL_CRIT))
        else $error("collision level out of range");

    // A held critical level always yields the critical alarm.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (collision_level == LEVEL_CRIT)) |-> (alarm_level == ALARM_CRIT))
        else $error("critical level without critical alarm");

    // Input backpressure only arises from a full pipe with a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output stall");
`endif

endmodule

@@ rtl/cag_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Collision alarm grader configuration registers
// Write-only register file with reset defaults and width truncation.
// ----------------------------------------------------------------------------
module cag_cfg_regs
    import cag_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRONT_WARN_DIST: cfg_reg.front_warn_dist <= cfg_data;
                REG_FRONT_CRIT_DIST: cfg_reg.front_crit_dist <= cfg_data;
                REG_TTC_WARN_LIMIT:  cfg_reg.ttc_warn_limit  <= cfg_data[LIMIT_W-1:0];
                REG_TTC_CRIT_LIMIT:  cfg_reg.ttc_crit_limit  <= cfg_data[LIMIT_W-1:0];
                REG_SIDE_RANGE:      cfg_reg.side_range      <= cfg_data;
                REG_SIDE_MIN_SPEED:  cfg_reg.side_min_speed  <= cfg_data[SPEED_W-1:0];
                REG_OVERSPEED_LIMIT: cfg_reg.overspeed_limit <= cfg_data[SPEED_W-1:0];
                REG_SENSOR_MAX_DIST: cfg_reg.sensor_max_dist <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/cag_input_stage.sv @@
// ----------------------------------------------------------------------------
// Collision alarm grader input stage
// Captures one sensor beat and pre-scales speed and front distance.
// ----------------------------------------------------------------------------
module cag_input_stage
    import cag_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SPEED_W-1:0] speed,
    input  logic [DIST_W-1:0]  front_dist,
    input  logic [DIST_W-1:0]  left_dist,
    input  logic [DIST_W-1:0]  right_dist,
    output logic               item_valid,
    input  logic               item_take,
    output item_t              item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  load;

    assign in_ready = !valid_reg || item_take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        item_next.speed      = speed;
        item_next.front_dist = front_dist;
        item_next.left_dist  = left_dist;
        item_next.right_dist = right_dist;
        item_next.speed_x25  = {{(SCALE_W-SPEED_W){1'b0}}, speed} * 17'd25;
        item_next.front_x9   = {{(SCALE_W-DIST_W){1'b0}}, front_dist} * 17'd9;
        valid_next           = load || (valid_reg && !item_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/cag_grade.sv @@
// ----------------------------------------------------------------------------
// Collision alarm grader decision stage
// Grades risk, filters de-escalation and registers the result beat.
// ----------------------------------------------------------------------------
module cag_grade
    import cag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        item_valid,
    output logic        item_take,
    input  item_t       item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  collision_level,
    output logic        blind_left,
    output logic        blind_right,
    output logic [1:0]  alarm_level,
    output logic        ttc_active
);

    logic [1:0]       held_reg;
    logic [1:0]       held_next;
    logic [CNT_W-1:0] settle_count_reg;
    logic [CNT_W-1:0] settle_count_next;
    logic [CNT_W-1:0] settle_inc;
    logic             out_valid_reg;
    logic [1:0]       level_reg;
    logic             blind_left_reg;
    logic             blind_right_reg;
    logic [1:0]       alarm_reg;
    logic             active_reg;
    logic             active;
    logic [PROD_W-1:0] prod_warn;
    logic [PROD_W-1:0] prod_crit;
    logic             ttc_warn;
    logic             ttc_crit;
    logic             crit;
    logic             warn;
    logic [1:0]       inst;
    logic             bl;
    logic             br;
    logic [1:0]       alarm_next;

    assign item_take = item_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        active    = (item.speed != '0) && (item.front_dist < cfg.sensor_max_dist);
        prod_warn = {{(PROD_W-LIMIT_W){1'b0}}, cfg.ttc_warn_limit}
                  * {{(PROD_W-SCALE_W){1'b0}}, item.speed_x25};
        prod_crit = {{(PROD_W-LIMIT_W){1'b0}}, cfg.ttc_crit_limit}
                  * {{(PROD_W-SCALE_W){1'b0}}, item.speed_x25};
        ttc_warn  = active && (item.front_dist != '0)
                  && ({{(PROD_W-SCALE_W){1'b0}}, item.front_x9} < prod_warn);
        ttc_crit  = active && (item.front_dist != '0)
                  && ({{(PROD_W-SCALE_W){1'b0}}, item.front_x9} < prod_crit);
        crit      = (item.front_dist < cfg.front_crit_dist) || ttc_crit;
        warn      = (item.front_dist < cfg.front_warn_dist) || ttc_warn;
        inst      = crit ? LEVEL_CRIT : (warn ? LEVEL_WARN : LEVEL_NONE);

        settle_inc        = settle_count_reg + 4'd1;
        held_next         = held_reg;
        settle_count_next = '0;
        if (inst > held_reg)
        begin
            held_next = inst;
        end
        else if (inst < held_reg)
        begin
            if (settle_inc >= HOLD_SAMPLES)
            begin
                held_next = inst;
            end
            else
            begin
                settle_count_next = settle_inc;
            end
        end

        bl = (item.speed > cfg.side_min_speed) && (item.left_dist < cfg.side_range);
        br = (item.speed > cfg.side_min_speed) && (item.right_dist < cfg.side_range);

        if (held_next == LEVEL_CRIT)
        begin
            alarm_next = ALARM_CRIT;
        end
        else if (held_next == LEVEL_WARN)
        begin
            alarm_next = ALARM_WARN;
        end
        else if (bl || br || (item.speed > cfg.overspeed_limit))
        begin
            alarm_next = ALARM_NOTICE;
        end
        else
        begin
            alarm_next = ALARM_QUIET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg         <= LEVEL_NONE;
            settle_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                held_reg         <= held_next;
                settle_count_reg <= settle_count_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            level_reg       <= held_next;
            blind_left_reg  <= bl;
            blind_right_reg <= br;
            alarm_reg       <= alarm_next;
            active_reg      <= active;
        end
    end

    assign out_valid       = out_valid_reg;
    assign collision_level = level_reg;
    assign blind_left      = blind_left_reg;
    assign blind_right     = blind_right_reg;
    assign alarm_level     = alarm_reg;
    assign ttc_active      = active_reg;

endmodule
